FILE: hdl/disparity_error_statistics_macros.svh
// ---------------------------------------------------------------------------
// disparity_error_statistics_macros
// assertion macros shared by the disparity error statistics modules
// ---------------------------------------------------------------------------
`ifndef DISPARITY_ERROR_STATISTICS_MACROS_SVH
`define DISPARITY_ERROR_STATISTICS_MACROS_SVH

// condition holds at every edge out of reset
`define DES_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define DES_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define DES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/des_pkg.sv
// ---------------------------------------------------------------------------
// des_pkg
// widths, constants and word types of the disparity error statistics block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package des_pkg;

   // frame size and accumulator widths
   localparam int MAX_PIXELS_LOG2 = 24;
   localparam int CNT_W           = MAX_PIXELS_LOG2 + 1;
   localparam int ABS_SUM_W       = CNT_W + 16;
   localparam int SQ_SUM_W        = CNT_W + 32;

   // pixel and result widths
   localparam int DATA_W      = 16;
   localparam int DIFF_W      = DATA_W + 1;
   localparam int ERR_W       = DATA_W;
   localparam int SQE_W       = 2 * ERR_W;
   localparam int RATIO_SHIFT = 16;
   localparam int RATIO_W     = RATIO_SHIFT + 1;
   localparam int OUT_W       = 16;
   localparam int ROOT_W      = SQE_W / 2 + 1;

   // back end step counter
   localparam int STEP_W = $clog2(SQ_SUM_W);
   localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SQ_SUM_W - 1);
   localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);

   // special values
   localparam logic [DATA_W-1:0]        PREC_RST     = 16'd16;
   localparam logic signed [DIFF_W-1:0] DIFF_POS_INF = 17'sh0FFFF;
   localparam logic signed [DIFF_W-1:0] DIFF_NEG_INF = 17'sh10000;
   localparam logic [OUT_W-1:0]         OUT_MAX      = 16'hFFFF;
   localparam logic [RATIO_W-1:0]       RATIO_ONE    = 17'h10000;

   // queue between front and back
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = $clog2(Q_DEPTH);
   localparam int Q_CW    = $clog2(Q_DEPTH + 1);

   // input word
   typedef struct packed {
      logic signed [DATA_W-1:0] disparity;
      logic                     disp_is_nan;
      logic                     disp_is_inf;
      logic signed [DATA_W-1:0] truth;
      logic                     truth_is_nan;
      logic                     truth_is_inf;
      logic                     last_pixel;
   } req_type;

   // result word
   typedef struct packed {
      logic signed [DIFF_W-1:0] diff_out;
      logic                     stats_valid;
      logic [RATIO_W-1:0]       ratio_nondense;
      logic [RATIO_W-1:0]       ratio_dense;
      logic [OUT_W-1:0]         rmse;
      logic [OUT_W-1:0]         mean_abs_error;
      logic                     infinite_error;
      logic                     no_valid_pixels;
   } rsp_type;

   // queue entry
   typedef struct packed {
      logic signed [DIFF_W-1:0] diff;
      logic                     last;
   } q_entry_type;

   // frame accumulators
   typedef struct packed {
      logic [CNT_W-1:0]     valid_cnt;
      logic [CNT_W-1:0]     nondense_cnt;
      logic [CNT_W-1:0]     correct_cnt;
      logic [ABS_SUM_W-1:0] abs_sum;
      logic [SQ_SUM_W-1:0]  sq_sum;
      logic                 inf_seen;
   } stats_type;

   // frame totals handed to the back end
   typedef struct packed {
      logic      busy;
      stats_type stats;
   } snap_type;

endpackage

FILE: hdl/des_fifo.sv
// ---------------------------------------------------------------------------
// des_fifo
// short show-ahead queue of per-pixel words between front and back end
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "disparity_error_statistics_macros.svh"

module des_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_i,
   input  des_pkg::q_entry_type push_data_i,
   output logic                 full_o,
   input  logic                 pop_i,
   output logic                 valid_o,
   output des_pkg::q_entry_type pop_data_o
);

   des_pkg::q_entry_type          entry_ff [des_pkg::Q_DEPTH];
   logic [des_pkg::Q_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [des_pkg::Q_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [des_pkg::Q_CW-1:0]      count_ff, count_in;

   // status
   assign full_o     = (count_ff == des_pkg::Q_CW'(des_pkg::Q_DEPTH));
   assign valid_o    = (count_ff != '0);
   assign pop_data_o = entry_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = push_i ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_i ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_i && !pop_i) begin
         count_in = count_ff + 1'b1;
      end else if (pop_i && !push_i) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push_i) begin
         entry_ff[wr_ptr_ff] <= push_data_i;
      end
   end

   `DES_ASSERT_IMPLY(a_q_no_overrun, clock, reset, push_i && !pop_i, !full_o, "queue overrun")
   `DES_ASSERT_IMPLY(a_q_no_underrun, clock, reset, pop_i, count_ff != '0, "queue underrun")

endmodule

FILE: hdl/des_front.sv
// ---------------------------------------------------------------------------
// des_front
// pixel classification and frame accumulation, two register stages
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "disparity_error_statistics_macros.svh"

module des_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  des_pkg::req_type                req_data,
   input  logic                            csr_we,
   input  logic [des_pkg::DATA_W-1:0]      csr_wdata,
   output logic                            q_push,
   output des_pkg::q_entry_type            q_data,
   input  logic                            q_full,
   output des_pkg::snap_type               snap,
   input  logic                            snap_release
);

   // classified pixel
   typedef struct packed {
      logic signed [des_pkg::DIFF_W-1:0] diff;
      logic [des_pkg::ERR_W-1:0]         err;
      logic                              cnt_valid;
      logic                              cnt_nd;
      logic                              correct;
      logic                              inf_err;
      logic                              last;
   } cls_type;

   // classified pixel with its squared error
   typedef struct packed {
      cls_type                    cls;
      logic [des_pkg::SQE_W-1:0]  sq;
   } sq_stage_type;

   logic [des_pkg::DATA_W-1:0]        prec_ff, prec_in;
   logic                              s1_valid_ff, s1_valid_in;
   cls_type                           s1_ff, s1_in;
   logic                              s2_valid_ff, s2_valid_in;
   sq_stage_type                      s2_ff, s2_in;
   des_pkg::stats_type                acc_ff, acc_in, acc_upd;
   des_pkg::stats_type                snap_ff, snap_in;
   logic                              snap_busy_ff, snap_busy_in;

   logic signed [des_pkg::DIFF_W-1:0] truth_ext, disp_ext, diff_raw, diff_neg;
   logic [des_pkg::ERR_W-1:0]         err_raw;
   logic                              finite, one_inf, both_inf;
   logic                              accept, s2_go, s2_free, s1_free;

   // saturating counter step
   function automatic logic [des_pkg::CNT_W-1:0] cnt_inc(
      input logic [des_pkg::CNT_W-1:0] c,
      input logic                      en
   );
      logic [des_pkg::CNT_W:0] s;
      s = {1'b0, c} + {{des_pkg::CNT_W{1'b0}}, en};
      cnt_inc = s[des_pkg::CNT_W] ? {des_pkg::CNT_W{1'b1}} : s[des_pkg::CNT_W-1:0];
   endfunction

   // saturating l1 sum
   function automatic logic [des_pkg::ABS_SUM_W-1:0] abs_add(
      input logic [des_pkg::ABS_SUM_W-1:0] a,
      input logic [des_pkg::ERR_W-1:0]     v
   );
      logic [des_pkg::ABS_SUM_W:0] s;
      s = {1'b0, a} + {{(des_pkg::ABS_SUM_W + 1 - des_pkg::ERR_W){1'b0}}, v};
      abs_add = s[des_pkg::ABS_SUM_W] ? {des_pkg::ABS_SUM_W{1'b1}}
                                      : s[des_pkg::ABS_SUM_W-1:0];
   endfunction

   // saturating l2 sum
   function automatic logic [des_pkg::SQ_SUM_W-1:0] sq_add(
      input logic [des_pkg::SQ_SUM_W-1:0] a,
      input logic [des_pkg::SQE_W-1:0]    v
   );
      logic [des_pkg::SQ_SUM_W:0] s;
      s = {1'b0, a} + {{(des_pkg::SQ_SUM_W + 1 - des_pkg::SQE_W){1'b0}}, v};
      sq_add = s[des_pkg::SQ_SUM_W] ? {des_pkg::SQ_SUM_W{1'b1}}
                                    : s[des_pkg::SQ_SUM_W-1:0];
   endfunction

   // stage handshake
   always_comb begin
      s2_go     = s2_valid_ff && !q_full && (!s2_ff.cls.last || !snap_busy_ff);
      s2_free   = !s2_valid_ff || s2_go;
      s1_free   = !s1_valid_ff || s2_free;
      req_ready = s1_free;
      accept    = req_valid && req_ready;
   end

   // tolerance register
   always_comb begin
      prec_in = csr_we ? csr_wdata : prec_ff;
   end

   // classify the incoming pixel
   always_comb begin
      truth_ext = {req_data.truth[des_pkg::DATA_W-1], req_data.truth};
      disp_ext  = {req_data.disparity[des_pkg::DATA_W-1], req_data.disparity};
      diff_raw  = truth_ext - disp_ext;
      diff_neg  = -diff_raw;
      err_raw   = diff_raw[des_pkg::DIFF_W-1] ? diff_neg[des_pkg::ERR_W-1:0]
                                              : diff_raw[des_pkg::ERR_W-1:0];
      both_inf  = req_data.truth_is_inf && req_data.disp_is_inf;
      one_inf   = req_data.truth_is_inf ^ req_data.disp_is_inf;

      s1_in.cnt_valid = !req_data.truth_is_nan;
      s1_in.cnt_nd    = !req_data.truth_is_nan && !req_data.disp_is_nan;
      finite          = s1_in.cnt_nd && !req_data.truth_is_inf && !req_data.disp_is_inf;
      s1_in.inf_err   = s1_in.cnt_nd && one_inf;
      s1_in.correct   = (s1_in.cnt_nd && both_inf)
                        || (finite && ({1'b0, err_raw} <= {1'b0, prec_ff}));
      s1_in.err       = finite ? err_raw : '0;
      s1_in.last      = req_data.last_pixel;
      if (finite) begin
         s1_in.diff = diff_raw;
      end else if (s1_in.inf_err) begin
         s1_in.diff = req_data.truth_is_inf ? des_pkg::DIFF_POS_INF : des_pkg::DIFF_NEG_INF;
      end else begin
         s1_in.diff = '0;
      end
   end

   // stage valids
   always_comb begin
      s1_valid_in = s1_free ? accept : s1_valid_ff;
      s2_valid_in = s2_free ? s1_valid_ff : s2_valid_ff;
   end

   // squared error
   always_comb begin
      s2_in.cls = s1_ff;
      s2_in.sq  = {{(des_pkg::SQE_W - des_pkg::ERR_W){1'b0}}, s1_ff.err}
                  * {{(des_pkg::SQE_W - des_pkg::ERR_W){1'b0}}, s1_ff.err};
   end

   // accumulate, hand over totals on the last pixel
   always_comb begin
      acc_upd.valid_cnt    = cnt_inc(acc_ff.valid_cnt, s2_ff.cls.cnt_valid);
      acc_upd.nondense_cnt = cnt_inc(acc_ff.nondense_cnt, s2_ff.cls.cnt_nd);
      acc_upd.correct_cnt  = cnt_inc(acc_ff.correct_cnt, s2_ff.cls.correct);
      acc_upd.abs_sum      = abs_add(acc_ff.abs_sum, s2_ff.cls.err);
      acc_upd.sq_sum       = sq_add(acc_ff.sq_sum, s2_ff.sq);
      acc_upd.inf_seen     = acc_ff.inf_seen || s2_ff.cls.inf_err;

      acc_in       = acc_ff;
      snap_in      = snap_ff;
      snap_busy_in = snap_busy_ff && !snap_release;
      if (s2_go) begin
         if (s2_ff.cls.last) begin
            acc_in       = '0;
            snap_in      = acc_upd;
            snap_busy_in = 1'b1;
         end else begin
            acc_in = acc_upd;
         end
      end
   end

   // queue word
   always_comb begin
      q_push      = s2_go;
      q_data.diff = s2_ff.cls.diff;
      q_data.last = s2_ff.cls.last;
      snap.busy   = snap_busy_ff;
      snap.stats  = snap_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         prec_ff      <= des_pkg::PREC_RST;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         snap_busy_ff <= 1'b0;
      end else begin
         prec_ff      <= prec_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         acc_ff       <= acc_in;
         snap_busy_ff <= snap_busy_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s2_free && s1_valid_ff) begin
         s2_ff <= s2_in;
      end
      snap_ff <= snap_in;
   end

   `DES_ASSERT_IMPLY(a_release_when_busy, clock, reset, snap_release, snap_busy_ff,
      "totals released while none were pending")
   `DES_ASSERT_NEXT(a_frame_cleared, clock, reset, s2_go && s2_ff.cls.last,
      acc_ff.valid_cnt == '0 && acc_ff.nondense_cnt == '0 && !acc_ff.inf_seen,
      "accumulators not cleared after last pixel")

endmodule

FILE: hdl/des_back.sv
// ---------------------------------------------------------------------------
// des_back
// result formatting with shared restoring divider and bit-serial root
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "disparity_error_statistics_macros.svh"

module des_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  des_pkg::q_entry_type q_data,
   output logic                 q_pop,
   input  des_pkg::snap_type    snap,
   output logic                 snap_release,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output des_pkg::rsp_type     rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_SQRT = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   typedef enum logic [1:0] {
      OP_RATIO_ND = 2'd0,
      OP_RATIO_D  = 2'd1,
      OP_MAE      = 2'd2,
      OP_MSE      = 2'd3
   } op_type;

   state_type                              state_ff, state_in;
   op_type                                 op_ff, op_in, op_load;
   logic [des_pkg::STEP_W-1:0]             step_ff, step_in;
   logic [des_pkg::CNT_W-1:0]              rem_ff, rem_in;
   logic [des_pkg::SQ_SUM_W-1:0]           quo_ff, quo_in;
   logic [des_pkg::CNT_W-1:0]              divisor_ff, divisor_in;
   logic [des_pkg::ROOT_W:0]               sq_rem_ff, sq_rem_in;
   logic [2*des_pkg::ROOT_W-1:0]           rad_ff, rad_in;
   logic [des_pkg::ROOT_W-1:0]             root_ff, root_in;
   logic [des_pkg::RATIO_W-1:0]            ratio_nd_ff, ratio_nd_in;
   logic [des_pkg::RATIO_W-1:0]            ratio_d_ff, ratio_d_in;
   logic [des_pkg::OUT_W-1:0]              mae_ff, mae_in;
   logic [des_pkg::OUT_W-1:0]              rmse_ff, rmse_in;
   logic signed [des_pkg::DIFF_W-1:0]      diff_hold_ff, diff_hold_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   des_pkg::rsp_type                       rsp_data_ff, rsp_data_in;

   logic                                   out_free, nd_zero, v_zero;
   logic [des_pkg::SQ_SUM_W-1:0]           dvd_load;
   logic [des_pkg::CNT_W-1:0]              dsr_load;
   logic [des_pkg::CNT_W:0]                r_shift, r_sub;
   logic                                   div_ge;
   logic [des_pkg::CNT_W-1:0]              rem_step;
   logic [des_pkg::SQ_SUM_W-1:0]           quo_step;
   logic [des_pkg::ROOT_W+2:0]             s_shift, s_trial, s_sub;
   logic                                   sqrt_ge;
   logic [des_pkg::ROOT_W:0]               sq_rem_step;
   logic [des_pkg::ROOT_W-1:0]             root_step;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign nd_zero  = (snap.stats.nondense_cnt == '0);
   assign v_zero   = (snap.stats.valid_cnt == '0);

   // operand selection for the next division
   always_comb begin
      op_load = OP_RATIO_ND;
      if (state_ff == ST_DIV) begin
         case (op_ff)
            OP_RATIO_ND: op_load = OP_RATIO_D;
            OP_RATIO_D:  op_load = OP_MAE;
            OP_MAE:      op_load = OP_MSE;
            default:     op_load = OP_MSE;
         endcase
      end
      case (op_load)
         OP_RATIO_ND, OP_RATIO_D: begin
            dvd_load = {{(des_pkg::SQ_SUM_W - des_pkg::CNT_W - des_pkg::RATIO_SHIFT){1'b0}},
                        snap.stats.correct_cnt, {des_pkg::RATIO_SHIFT{1'b0}}};
         end
         OP_MAE: begin
            dvd_load = {{(des_pkg::SQ_SUM_W - des_pkg::ABS_SUM_W){1'b0}}, snap.stats.abs_sum};
         end
         default: begin
            dvd_load = snap.stats.sq_sum;
         end
      endcase
      dsr_load = (op_load == OP_RATIO_D) ? snap.stats.valid_cnt : snap.stats.nondense_cnt;
   end

   // one quotient bit per cycle
   always_comb begin
      r_shift  = {rem_ff, quo_ff[des_pkg::SQ_SUM_W-1]};
      r_sub    = r_shift - {1'b0, divisor_ff};
      div_ge   = (r_shift >= {1'b0, divisor_ff});
      rem_step = div_ge ? r_sub[des_pkg::CNT_W-1:0] : r_shift[des_pkg::CNT_W-1:0];
      quo_step = {quo_ff[des_pkg::SQ_SUM_W-2:0], div_ge};
   end

   // one root bit per cycle
   always_comb begin
      s_shift     = {sq_rem_ff, rad_ff[2*des_pkg::ROOT_W-1 -: 2]};
      s_trial     = {1'b0, root_ff, 2'b01};
      s_sub       = s_shift - s_trial;
      sqrt_ge     = (s_shift >= s_trial);
      sq_rem_step = sqrt_ge ? s_sub[des_pkg::ROOT_W:0] : s_shift[des_pkg::ROOT_W:0];
      root_step   = {root_ff[des_pkg::ROOT_W-2:0], sqrt_ge};
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      step_in      = step_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      divisor_in   = divisor_ff;
      sq_rem_in    = sq_rem_ff;
      rad_in       = rad_ff;
      root_in      = root_ff;
      ratio_nd_in  = ratio_nd_ff;
      ratio_d_in   = ratio_d_ff;
      mae_in       = mae_ff;
      rmse_in      = rmse_ff;
      diff_hold_in = diff_hold_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      snap_release = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               if (q_data.last) begin
                  diff_hold_in = q_data.diff;
                  op_in        = op_load;
                  step_in      = '0;
                  rem_in       = '0;
                  quo_in       = dvd_load;
                  divisor_in   = dsr_load;
                  state_in     = ST_DIV;
               end else begin
                  rsp_valid_in         = 1'b1;
                  rsp_data_in          = '0;
                  rsp_data_in.diff_out = q_data.diff;
               end
            end
         end
         ST_DIV: begin
            rem_in  = rem_step;
            quo_in  = quo_step;
            step_in = step_ff + 1'b1;
            if (step_ff == des_pkg::DIV_LAST) begin
               step_in    = '0;
               rem_in     = '0;
               quo_in     = dvd_load;
               divisor_in = dsr_load;
               op_in      = op_load;
               case (op_ff)
                  OP_RATIO_ND: ratio_nd_in = quo_step[des_pkg::RATIO_W-1:0];
                  OP_RATIO_D:  ratio_d_in  = quo_step[des_pkg::RATIO_W-1:0];
                  OP_MAE: begin
                     mae_in = (|quo_step[des_pkg::SQ_SUM_W-1:des_pkg::OUT_W])
                              ? des_pkg::OUT_MAX : quo_step[des_pkg::OUT_W-1:0];
                  end
                  default: begin
                     rad_in    = quo_step[2*des_pkg::ROOT_W-1:0];
                     sq_rem_in = '0;
                     root_in   = '0;
                     state_in  = ST_SQRT;
                  end
               endcase
            end
         end
         ST_SQRT: begin
            sq_rem_in = sq_rem_step;
            root_in   = root_step;
            rad_in    = {rad_ff[2*des_pkg::ROOT_W-3:0], 2'b00};
            step_in   = step_ff + 1'b1;
            if (step_ff == des_pkg::SQRT_LAST) begin
               step_in  = '0;
               rmse_in  = root_step[des_pkg::ROOT_W-1] ? des_pkg::OUT_MAX
                                                      : root_step[des_pkg::OUT_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.diff_out        = diff_hold_ff;
               rsp_data_in.stats_valid     = 1'b1;
               rsp_data_in.ratio_nondense  = nd_zero ? '0 : ratio_nd_ff;
               rsp_data_in.ratio_dense     = v_zero ? '0 : ratio_d_ff;
               rsp_data_in.rmse            = nd_zero ? '0 :
                                             (snap.stats.inf_seen ? des_pkg::OUT_MAX : rmse_ff);
               rsp_data_in.mean_abs_error  = nd_zero ? '0 :
                                             (snap.stats.inf_seen ? des_pkg::OUT_MAX : mae_ff);
               rsp_data_in.infinite_error  = snap.stats.inf_seen;
               rsp_data_in.no_valid_pixels = nd_zero || v_zero;
               snap_release                = 1'b1;
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_RATIO_ND;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      divisor_ff   <= divisor_in;
      sq_rem_ff    <= sq_rem_in;
      rad_ff       <= rad_in;
      root_ff      <= root_in;
      ratio_nd_ff  <= ratio_nd_in;
      ratio_d_ff   <= ratio_d_in;
      mae_ff       <= mae_in;
      rmse_ff      <= rmse_in;
      diff_hold_ff <= diff_hold_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `DES_ASSERT_IMPLY(a_totals_pending, clock, reset, state_ff != ST_IDLE, snap.busy,
      "frame statistics computed without pending totals")
   `DES_ASSERT_IMPLY(a_ratio_bound, clock, reset, rsp_valid_ff && rsp_data_ff.stats_valid,
      rsp_data_ff.ratio_dense <= des_pkg::RATIO_ONE
      && rsp_data_ff.ratio_nondense <= des_pkg::RATIO_ONE,
      "ratio above one")

endmodule

FILE: hdl/disparity_error_statistics.sv
// ---------------------------------------------------------------------------
// disparity_error_statistics
// per-pixel disparity error and per-frame correct pixel ratio, rmse and mae
// ---------------------------------------------------------------------------
//  channel   direction  ports                      word
//  req       in         req_valid/req_ready        des_pkg::req_type
//  rsp       out        rsp_valid/rsp_ready        des_pkg::rsp_type
//  csr       in         csr_we                     precision, 16 bit
//
//  a pixel word is taken every cycle while req_ready is high; its result word
//  passes two front stages, the queue and the output register
//  a last pixel holds the back end for the pop, four 57-step divisions on
//  one shared restoring divider, 17 root steps and the output cycle; the
//  front keeps taking pixels of the next frame until the queue fills or its
//  last pixel arrives
//  synchronous reset clears the counts and sets precision to 16; no sweep
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module disparity_error_statistics (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  des_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output des_pkg::rsp_type           rsp_data,
   input  logic                       csr_we,
   input  logic [des_pkg::DATA_W-1:0] csr_wdata
);

   logic                 q_push, q_full, q_pop, q_valid, snap_release;
   des_pkg::q_entry_type q_push_data, q_pop_data;
   des_pkg::snap_type    snap;

   // classification and accumulation
   des_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .q_push       (q_push),
      .q_data       (q_push_data),
      .q_full       (q_full),
      .snap         (snap),
      .snap_release (snap_release)
   );

   // decoupling queue
   des_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_i      (q_push),
      .push_data_i (q_push_data),
      .full_o      (q_full),
      .pop_i       (q_pop),
      .valid_o     (q_valid),
      .pop_data_o  (q_pop_data)
   );

   // statistics and output word
   des_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_data       (q_pop_data),
      .q_pop        (q_pop),
      .snap         (snap),
      .snap_release (snap_release),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule

FILE: bench/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the disparity error statistics block
// ---------------------------------------------------------------------------
//  a short directed list covers the value extremes, the nan, infinity and
//  occlusion cases and frames with no counted pixels; random frames follow
//  under several precision settings, the extremes among them
//  every accepted pixel word is scored by a local model of the frame
//  accumulators and compared field by field with the result words in order
//  the sender idles in random bursts, the receiver stalls in random modes and
//  now and then holds off long enough to back the block up
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam int  PHASE_WORDS   = 300;
   localparam int  TAIL_CYCLES   = 300;
   localparam int  DRAIN_LIMIT   = 200000;
   localparam int  HOLD_CYCLES   = 400;
   localparam int  HOLD_SPACING  = 700;
   localparam real RUN_LIMIT_NS  = 30_000_000.0;

   logic                        clock       = 1'b0;
   logic                        reset       = 1'b1;
   logic                        req_valid   = 1'b0;
   logic                        req_ready;
   des_pkg::req_type            req_data    = '0;
   logic                        rsp_valid;
   logic                        rsp_ready   = 1'b0;
   des_pkg::rsp_type            rsp_data;
   logic                        csr_we      = 1'b0;
   logic [des_pkg::DATA_W-1:0]  csr_wdata   = '0;

   // pixel words waiting to be sent and results predicted for sent words
   des_pkg::req_type            pixel_queue[$];
   des_pkg::rsp_type            predicted_results[$];

   // model copy of the precision register and the frame accumulators
   logic [des_pkg::DATA_W-1:0]  prec_now     = des_pkg::PREC_RST;
   longint unsigned             cnt_valid    = 0;
   longint unsigned             cnt_nondense = 0;
   longint unsigned             cnt_correct  = 0;
   longint unsigned             sum_abs      = 0;
   longint unsigned             sum_sq       = 0;
   bit                          frame_inf    = 1'b0;

   int unsigned                 words_in     = 0;
   int unsigned                 words_out    = 0;
   int unsigned                 mismatches   = 0;

   // sender and receiver pacing
   int unsigned                 burst_left   = 0;
   int unsigned                 gap_left     = 0;
   int unsigned                 hold_left    = 0;
   int unsigned                 next_hold_at = 200;
   int unsigned                 rx_mode      = 0;
   int unsigned                 rx_mode_left = 0;

   disparity_error_statistics u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // saturating add at a given accumulator width
   function automatic longint unsigned sat_add(longint unsigned acc, longint unsigned v,
                                               int w);
      longint unsigned top;
      top = (64'd1 << w) - 64'd1;
      if (acc > top) acc = top;
      if (v > top - acc) return top;
      return acc + v;
   endfunction

   // integer square root, one result bit per pass
   function automatic longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int i = 31; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if (trial * trial <= x) root = trial;
      end
      return root;
   endfunction

   // score one pixel word against the frame accumulators
   function automatic des_pkg::rsp_type score_pixel(des_pkg::req_type px);
      des_pkg::rsp_type r;
      int               diff;
      longint unsigned  mag;
      longint unsigned  root;
      longint unsigned  mean;
      r    = '0;
      diff = 0;
      if (!px.truth_is_nan) begin
         cnt_valid = sat_add(cnt_valid, 1, des_pkg::CNT_W);
         if (!px.disp_is_nan) begin
            cnt_nondense = sat_add(cnt_nondense, 1, des_pkg::CNT_W);
            if (px.truth_is_inf && px.disp_is_inf) begin
               // occlusion found on both sides counts as exact
               cnt_correct = sat_add(cnt_correct, 1, des_pkg::CNT_W);
            end else if (px.truth_is_inf || px.disp_is_inf) begin
               frame_inf = 1'b1;
               diff      = px.truth_is_inf ? 65535 : -65536;
            end else begin
               diff = int'($signed(px.truth)) - int'($signed(px.disparity));
               mag  = longint'(diff < 0 ? -diff : diff);
               if (mag <= longint'(prec_now))
                  cnt_correct = sat_add(cnt_correct, 1, des_pkg::CNT_W);
               sum_abs = sat_add(sum_abs, mag, des_pkg::ABS_SUM_W);
               sum_sq  = sat_add(sum_sq, mag * mag, des_pkg::SQ_SUM_W);
            end
         end
      end
      r.diff_out = des_pkg::DIFF_W'(diff);

      // frame statistics on the last pixel, then clear
      if (px.last_pixel) begin
         r.stats_valid = 1'b1;
         if (cnt_nondense != 0) begin
            r.ratio_nondense = des_pkg::RATIO_W'((cnt_correct << des_pkg::RATIO_SHIFT)
                                                 / cnt_nondense);
            if (frame_inf) begin
               r.rmse           = des_pkg::OUT_MAX;
               r.mean_abs_error = des_pkg::OUT_MAX;
            end else begin
               root             = floor_sqrt(sum_sq / cnt_nondense);
               mean             = sum_abs / cnt_nondense;
               r.rmse           = (root > 65535) ? des_pkg::OUT_MAX : des_pkg::OUT_W'(root);
               r.mean_abs_error = (mean > 65535) ? des_pkg::OUT_MAX : des_pkg::OUT_W'(mean);
            end
         end
         if (cnt_valid != 0)
            r.ratio_dense = des_pkg::RATIO_W'((cnt_correct << des_pkg::RATIO_SHIFT)
                                              / cnt_valid);
         r.infinite_error  = frame_inf;
         r.no_valid_pixels = (cnt_nondense == 0 || cnt_valid == 0);
         cnt_valid    = 0;
         cnt_nondense = 0;
         cnt_correct  = 0;
         sum_abs      = 0;
         sum_sq       = 0;
         frame_inf    = 1'b0;
      end
      return r;
   endfunction

   function automatic des_pkg::req_type pixel_word(int d, bit dn, bit di, int t, bit tn,
                                                   bit ti, bit last);
      des_pkg::req_type p;
      p.disparity    = des_pkg::DATA_W'(d);
      p.disp_is_nan  = dn;
      p.disp_is_inf  = di;
      p.truth        = des_pkg::DATA_W'(t);
      p.truth_is_nan = tn;
      p.truth_is_inf = ti;
      p.last_pixel   = last;
      return p;
   endfunction

   // random pixel, mostly with truth near the disparity around the tolerance
   function automatic des_pkg::req_type random_pixel(int unsigned tnan, int unsigned dnan,
                                                     int unsigned infp, bit last);
      des_pkg::req_type p;
      int               span;
      int               off;
      p           = '0;
      p.disparity = des_pkg::DATA_W'($urandom);
      if ($urandom_range(0, 15) == 0) p.disparity = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      if ($urandom_range(0, 9) < 7) begin
         span    = (prec_now > 2000) ? 2000 : int'(prec_now) + 4;
         off     = int'($urandom_range(0, 2 * span)) - span;
         p.truth = des_pkg::DATA_W'(int'($signed(p.disparity)) + off);
      end else begin
         p.truth = des_pkg::DATA_W'($urandom);
      end
      if ($urandom_range(0, 15) == 0) p.truth = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      p.truth_is_nan = ($urandom_range(0, 99) < tnan);
      p.disp_is_nan  = ($urandom_range(0, 99) < dnan);
      p.truth_is_inf = ($urandom_range(0, 99) < infp);
      p.disp_is_inf  = ($urandom_range(0, 99) < infp);
      p.last_pixel   = last;
      return p;
   endfunction

   task automatic note_mismatch(string what, longint want, longint got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s mismatch on result word %0d: expected %0d, got %0d",
                  $time, what, words_out, want, got);
   endtask

   // wait until the sender is empty and every predicted word has come back
   task automatic wait_drained();
      int n;
      n = 0;
      while ((pixel_queue.size() != 0 || req_valid || predicted_results.size() != 0)
             && n < DRAIN_LIMIT) begin
         @(negedge clock);
         n++;
      end
   endtask

   // sender: bursts of random length with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (gap_left != 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pixel_queue.size() != 0) begin
            req_data  <= pixel_queue.pop_front();
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                         : $urandom_range(1, 20);
               gap_left   <= ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40)
                                                         : $urandom_range(0, 3);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // predict the result of every accepted pixel word
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         predicted_results.push_back(score_pixel(req_data));
         words_in <= words_in + 1;
      end
   end

   // receiver: random stall modes plus an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (words_in >= next_hold_at) begin
         hold_left    <= HOLD_CYCLES;
         next_hold_at <= next_hold_at + HOLD_SPACING;
         rsp_ready    <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode      <= $urandom_range(0, 2);
            rx_mode_left <= $urandom_range(10, 150);
         end else begin
            rx_mode_left <= rx_mode_left - 1;
         end
         case (rx_mode)
            0: begin
               rsp_ready <= 1'b1;
            end
            1: begin
               rsp_ready <= $urandom_range(0, 1);
            end
            default: begin
               rsp_ready <= ($urandom_range(0, 3) == 0);
            end
         endcase
      end
   end

   // compare each result word with the oldest prediction
   always @(posedge clock) begin
      des_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_results.size() == 0) begin
            note_mismatch("unpredicted word", -1, $signed(rsp_data.diff_out));
         end else begin
            want = predicted_results.pop_front();
            if (rsp_data.diff_out !== want.diff_out)
               note_mismatch("diff_out", $signed(want.diff_out), $signed(rsp_data.diff_out));
            if (rsp_data.stats_valid !== want.stats_valid)
               note_mismatch("stats_valid", want.stats_valid, rsp_data.stats_valid);
            if (rsp_data.ratio_nondense !== want.ratio_nondense)
               note_mismatch("ratio_nondense", want.ratio_nondense, rsp_data.ratio_nondense);
            if (rsp_data.ratio_dense !== want.ratio_dense)
               note_mismatch("ratio_dense", want.ratio_dense, rsp_data.ratio_dense);
            if (rsp_data.rmse !== want.rmse)
               note_mismatch("rmse", want.rmse, rsp_data.rmse);
            if (rsp_data.mean_abs_error !== want.mean_abs_error)
               note_mismatch("mean_abs_error", want.mean_abs_error, rsp_data.mean_abs_error);
            if (rsp_data.infinite_error !== want.infinite_error)
               note_mismatch("infinite_error", want.infinite_error, rsp_data.infinite_error);
            if (rsp_data.no_valid_pixels !== want.no_valid_pixels)
               note_mismatch("no_valid_pixels", want.no_valid_pixels, rsp_data.no_valid_pixels);
         end
         words_out <= words_out + 1;
      end
   end

   // stimulus: directed frames, then random frames per precision setting
   initial begin
      logic [des_pkg::DATA_W-1:0] prec_plan[6];
      int                         queued;
      int                         len;
      int unsigned                style;
      int unsigned                tnan;
      int unsigned                dnan;
      int unsigned                infp;

      prec_plan[0] = 16'd0;
      prec_plan[1] = 16'hFFFF;
      prec_plan[2] = des_pkg::DATA_W'($urandom_range(1, 40));
      prec_plan[3] = des_pkg::DATA_W'($urandom);
      prec_plan[4] = 16'd1;
      prec_plan[5] = des_pkg::DATA_W'($urandom_range(0, 400));

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed frames at the reset tolerance
      pixel_queue.push_back(pixel_word(-32768, 0, 0, 32767, 0, 0, 1));
      pixel_queue.push_back(pixel_word(32767, 0, 0, -32768, 0, 0, 1));
      // exact, at tolerance, one past, nan disparity, last pixel skipped
      pixel_queue.push_back(pixel_word(100, 0, 0, 100, 0, 0, 0));
      pixel_queue.push_back(pixel_word(100, 0, 0, 116, 0, 0, 0));
      pixel_queue.push_back(pixel_word(100, 0, 0, 83, 0, 0, 0));
      pixel_queue.push_back(pixel_word(0, 1, 0, 50, 0, 0, 0));
      pixel_queue.push_back(pixel_word(5, 0, 0, 0, 1, 0, 1));
      // valid pixels but no non-nan disparity
      pixel_queue.push_back(pixel_word(0, 1, 1, 0, 0, 0, 0));
      pixel_queue.push_back(pixel_word(0, 1, 0, 0, 0, 1, 1));
      // frame of skipped pixels only
      pixel_queue.push_back(pixel_word(-1, 0, 1, -1, 1, 1, 1));
      // detected occlusion
      pixel_queue.push_back(pixel_word(0, 0, 1, 0, 0, 1, 1));
      // infinite truth, then infinite disparity
      pixel_queue.push_back(pixel_word(0, 0, 0, 0, 0, 1, 0));
      pixel_queue.push_back(pixel_word(10, 0, 0, 12, 0, 0, 1));
      pixel_queue.push_back(pixel_word(7, 0, 1, -3, 0, 0, 1));
      pixel_queue.push_back(pixel_word(-32768, 0, 1, -32768, 0, 1, 0));
      pixel_queue.push_back(pixel_word(32767, 1, 1, 32767, 0, 0, 1));

      foreach (prec_plan[p]) begin
         // sender pauses until the block is empty, then the tolerance changes
         wait_drained();
         repeat (20) @(negedge clock);
         @(posedge clock);
         csr_we    <= 1'b1;
         csr_wdata <= prec_plan[p];
         prec_now   = prec_plan[p];
         @(posedge clock);
         csr_we    <= 1'b0;
         @(negedge clock);

         queued = 0;
         while (queued < PHASE_WORDS) begin
            style = $urandom_range(0, 19);
            tnan  = (style == 0) ? 100 : (style < 10 ? 12 : 0);
            dnan  = (style == 1) ? 100 : (style < 10 ? 12 : 0);
            infp  = (style == 2) ? 30 : (style < 6 ? 3 : 0);
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 10);
            for (int k = 0; k < len; k++)
               pixel_queue.push_back(random_pixel(tnan, dnan, infp, k == len - 1));
            queued += len;
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (predicted_results.size() != 0) begin
         mismatches += predicted_results.size();
         $display("%0d predicted result words never arrived", predicted_results.size());
      end
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #(RUN_LIMIT_NS);
      $display("simulation failed");
      $finish;
   end

endmodule
